/* rtl/dnle_pkg.sv */
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  // Longest label kept; further characters are dropped and flagged
  localparam int LABEL_MAX = 62;
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = $clog2(LABEL_MAX);

  localparam logic [7:0] DOT_CHAR  = 8'd46;
  localparam logic [7:0] TERM_BYTE = 8'd0;

  localparam logic [CNT_W-1:0] LABEL_MAX_CNT = CNT_W'(LABEL_MAX);

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       label_overflow;
  } out_item_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_CHR  = 4'b0100,
    ST_TERM = 4'b1000
  } state_t;

endpackage

/* rtl/dnle_ram.sv */
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dns_name_label_encoder.sv */
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Encodes a dotted host name, one character per transfer, into DNS labels.
// ----------------------------------------------------------------------------
// Order: a label character is written to the label RAM and gives no result;
//   a dot or end of name moves to ST_LEN, and the length byte is then
//   registered out, followed by the label bytes read back from the label RAM
//   and, at end of name only, the terminator. No new character is taken
//   until the last byte of the label (or the terminator) has been issued.
// Reset: control state and character count clear; index and label RAM do not.
module dns_name_label_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dnle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dnle_pkg::out_item_t out_data
);

  dnle_pkg::state_t              state_r, state_nxt;
  logic [dnle_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [dnle_pkg::CNT_W-1:0]    snap_cnt_r, snap_cnt_nxt;
  logic                          snap_ovf_r, snap_ovf_nxt;
  logic                          snap_end_r, snap_end_nxt;
  logic [dnle_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dnle_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          in_xfer;
  logic                          slot_free;
  logic                          is_flush;
  logic                          last_chr;
  logic                          ram_we;
  logic                          ram_re;
  logic [dnle_pkg::ADDR_W-1:0]   ram_raddr;
  logic [7:0]                    ram_rdata;

  dnle_ram #(
    .WIDTH(8),
    .DEPTH(dnle_pkg::LABEL_MAX)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[dnle_pkg::ADDR_W-1:0]),
    .wdata (in_data.in_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != dnle_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign is_flush  = in_data.end_of_name || (in_data.in_char == dnle_pkg::DOT_CHAR);
  assign last_chr  = ((idx_r + dnle_pkg::ADDR_W'(1)) == snap_cnt_r[dnle_pkg::ADDR_W-1:0]);
  assign ram_we    = in_xfer && !is_flush && (count_r < dnle_pkg::LABEL_MAX_CNT);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: capture, length byte, label replay, terminator
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    snap_cnt_nxt  = snap_cnt_r;
    snap_ovf_nxt  = snap_ovf_r;
    snap_end_nxt  = snap_end_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      dnle_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (is_flush) begin
            snap_cnt_nxt = count_r;
            snap_ovf_nxt = ovf_r;
            snap_end_nxt = in_data.end_of_name;
            count_nxt    = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = dnle_pkg::ST_LEN;
          end else if (count_r < dnle_pkg::LABEL_MAX_CNT) begin
            count_nxt = count_r + dnle_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      dnle_pkg::ST_LEN: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = 8'(snap_cnt_r);
          out_data_nxt.run_last       = (snap_cnt_r == '0) && !snap_end_r;
          out_data_nxt.label_overflow = snap_ovf_r;
          idx_nxt                     = '0;
          // Prefetch the first label byte
          ram_re                      = 1'b1;
          ram_raddr                   = '0;
          if (snap_cnt_r != '0) begin
            state_nxt = dnle_pkg::ST_CHR;
          end else if (snap_end_r) begin
            state_nxt = dnle_pkg::ST_TERM;
          end else begin
            state_nxt = dnle_pkg::ST_IDLE;
          end
        end
      end

      dnle_pkg::ST_CHR: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = ram_rdata;
          out_data_nxt.run_last       = last_chr && !snap_end_r;
          out_data_nxt.label_overflow = 1'b0;
          if (last_chr) begin
            state_nxt = snap_end_r ? dnle_pkg::ST_TERM : dnle_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + dnle_pkg::ADDR_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_r + dnle_pkg::ADDR_W'(1);
          end
        end
      end

      dnle_pkg::ST_TERM: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = dnle_pkg::TERM_BYTE;
          out_data_nxt.run_last       = 1'b1;
          out_data_nxt.label_overflow = 1'b0;
          state_nxt                   = dnle_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dnle_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnle_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and snapshot registers
  always_ff @(posedge clk) begin
    snap_cnt_r <= snap_cnt_nxt;
    snap_ovf_r <= snap_ovf_nxt;
    snap_end_r <= snap_end_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
